// ===== sv/fcti_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcti_pkg
// Shared constants, types and the rule table of the two-input fuzzy
// controller.
// ---------------------------------------------------------------------------
package fcti_pkg;

	localparam int FRAC_BITS = 8;
	localparam int NSETS     = 5;
	localparam int XW        = 16;
	localparam int DEG_W     = FRAC_BITS + 1;
	localparam int PROD_W    = DEG_W + XW;
	localparam int ACC_W     = PROD_W + 2;
	localparam int WSUM_W    = DEG_W + 2;
	localparam int DV_W      = ACC_W + 2;
	localparam int QUO_W     = XW;
	// Entry register, membership division, three rule stages, divider setup,
	// quotient stages and the output register.
	localparam int LATENCY   = 1 + FRAC_BITS + 3 + 1 + QUO_W + 1;

	localparam logic [DEG_W-1:0] DEG_ONE = DEG_W'(1) << FRAC_BITS;
	localparam logic signed [XW-1:0] X_LIM = XW'(100 << FRAC_BITS);

	typedef logic signed [XW-1:0] sample_t;
	typedef sample_t centers_t [NSETS];
	typedef logic [1:0] setidx_t;
	typedef logic [2:0] cidx_t;

	// Output set for each pair (row: first input set, column: second input set).
	localparam cidx_t RULE_TBL [NSETS*NSETS] = '{
		3'd0, 3'd0, 3'd0, 3'd2, 3'd3,
		3'd1, 3'd1, 3'd1, 3'd2, 3'd3,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd1, 3'd2, 3'd3, 3'd3, 3'd3,
		3'd1, 3'd2, 3'd4, 3'd4, 3'd4
	};

	// Degrees of the two adjacent sets lo and lo+1 for one input.
	typedef struct packed {
		setidx_t          lo;
		logic [DEG_W-1:0] dlo;
		logic [DEG_W-1:0] dhi;
	} fuzz_t;

endpackage
`default_nettype wire

// ===== sv/fcti_fuzz.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcti_fuzz
// Clamps one input, finds its region between the centers and computes the
// membership degrees with a pipelined restoring divider, one bit a stage.
// ---------------------------------------------------------------------------
module fcti_fuzz (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  fcti_pkg::sample_t  x,
	input  fcti_pkg::centers_t centers,
	output logic               out_valid,
	output fcti_pkg::fuzz_t    fz
);
	import fcti_pkg::*;

	typedef enum logic [1:0] {
		RG_LOW  = 2'b01,
		RG_MID  = 2'b10,
		RG_HIGH = 2'b00
	} region_t;

	typedef struct packed {
		region_t              rg;
		setidx_t              lo;
		logic [XW-1:0]        den;
		logic [XW-1:0]        rem;
		logic [FRAC_BITS-1:0] quo;
	} dstep_t;

	sample_t          xc;
	dstep_t           entry;
	dstep_t           stg_s [FRAC_BITS+1];
	logic             vld_s [FRAC_BITS+1];
	dstep_t           nxt [FRAC_BITS];
	logic [DEG_W-1:0] dhi;

	always_comb begin
		xc = x;
		if (x < -X_LIM) xc = -X_LIM;
		if (x > X_LIM) xc = X_LIM;
		entry     = '0;
		entry.rg  = RG_HIGH;
		entry.lo  = setidx_t'(NSETS - 2);
		if (xc < centers[0]) begin
			entry.rg = RG_LOW;
			entry.lo = '0;
		end else begin
			// Walk downward so that the lowest matching region wins.
			for (int k = NSETS - 2; k >= 0; k--) begin
				if (xc < centers[k+1]) begin
					entry.rg  = RG_MID;
					entry.lo  = setidx_t'(k);
					entry.den = XW'(centers[k+1] - centers[k]);
					entry.rem = XW'(xc - centers[k]);
				end
			end
		end
	end

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_step
		logic [XW:0] r2;
		always_comb begin
			r2     = {stg_s[i].rem, 1'b0};
			nxt[i] = stg_s[i];
			if (r2 >= {1'b0, stg_s[i].den}) begin
				nxt[i].rem = XW'(r2 - {1'b0, stg_s[i].den});
				nxt[i].quo = {stg_s[i].quo[FRAC_BITS-2:0], 1'b1};
			end else begin
				nxt[i].rem = r2[XW-1:0];
				nxt[i].quo = {stg_s[i].quo[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= FRAC_BITS; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 0; i < FRAC_BITS; i++) vld_s[i+1] <= vld_s[i];
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= entry;
		for (int i = 0; i < FRAC_BITS; i++) stg_s[i+1] <= nxt[i];
	end

	always_comb begin
		case (stg_s[FRAC_BITS].rg)
			RG_LOW:  dhi = '0;
			RG_MID:  dhi = {1'b0, stg_s[FRAC_BITS].quo};
			default: dhi = DEG_ONE;
		endcase
	end

	assign fz.lo     = stg_s[FRAC_BITS].lo;
	assign fz.dhi    = dhi;
	assign fz.dlo    = DEG_ONE - dhi;
	assign out_valid = vld_s[FRAC_BITS];

endmodule
`default_nettype wire

// ===== sv/fcti_rules.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcti_rules
// Fires the four rules of two adjacent set pairs: min strengths, rule table
// lookup, weighting by the chosen center and summation over three stages.
// ---------------------------------------------------------------------------
module fcti_rules (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  fcti_pkg::fuzz_t                       fz_a,
	input  fcti_pkg::fuzz_t                       fz_b,
	input  fcti_pkg::centers_t                    centers,
	output logic                                  out_valid,
	output logic signed [fcti_pkg::ACC_W-1:0]     num,
	output logic [fcti_pkg::WSUM_W-1:0]           wsum
);
	import fcti_pkg::*;

	logic [DEG_W-1:0]          w_c [4];
	sample_t                   c_c [4];
	logic [DEG_W-1:0]          w_s1 [4];
	sample_t                   c_s1 [4];
	logic signed [PROD_W-1:0]  prod_s2 [4];
	logic [WSUM_W-1:0]         wsum_s2;
	logic signed [ACC_W-1:0]   num_s3;
	logic [WSUM_W-1:0]         wsum_s3;
	logic                      vld_s1, vld_s2, vld_s3;

	// Pair p uses set lo+PA of the first input and lo+PB of the second.
	for (genvar p = 0; p < 4; p++) begin : g_pair
		localparam bit PA = (p >= 2);
		localparam bit PB = ((p % 2) == 1);
		logic [DEG_W-1:0] da, db;
		cidx_t            sa, sb, ridx;
		always_comb begin
			da   = PA ? fz_a.dhi : fz_a.dlo;
			db   = PB ? fz_b.dhi : fz_b.dlo;
			sa   = {1'b0, fz_a.lo} + cidx_t'(PA);
			sb   = {1'b0, fz_b.lo} + cidx_t'(PB);
			ridx = RULE_TBL[5'(sa * 5 + sb)];
			w_c[p] = (da < db) ? da : db;
			c_c[p] = centers[0];
			for (int c = 1; c < NSETS; c++) begin
				if (ridx == cidx_t'(c)) c_c[p] = centers[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 4; p++) begin
			w_s1[p]    <= w_c[p];
			c_s1[p]    <= c_c[p];
			prod_s2[p] <= PROD_W'($signed({1'b0, w_s1[p]}) * c_s1[p]);
		end
		wsum_s2 <= WSUM_W'(w_s1[0]) + WSUM_W'(w_s1[1]) + WSUM_W'(w_s1[2]) + WSUM_W'(w_s1[3]);
		num_s3  <= ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1])
			+ ACC_W'(prod_s2[2]) + ACC_W'(prod_s2[3]);
		wsum_s3 <= wsum_s2;
	end

	assign out_valid = vld_s3;
	assign num       = num_s3;
	assign wsum      = wsum_s3;

endmodule
`default_nettype wire

// ===== sv/fcti_wdiv.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fcti_wdiv
// Pipelined restoring divider for the weighted average, rounded to nearest
// with ties away from zero; one quotient bit a stage.
// ---------------------------------------------------------------------------
module fcti_wdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [fcti_pkg::ACC_W-1:0] num,
	input  logic [fcti_pkg::WSUM_W-1:0]       wsum,
	output logic                              out_valid,
	output fcti_pkg::sample_t                 res
);
	import fcti_pkg::*;

	typedef struct packed {
		logic             neg;
		logic [DV_W-1:0]  rem;
		logic [DV_W-1:0]  dvs;
		logic [QUO_W-1:0] quo;
	} qstep_t;

	logic [ACC_W-1:0] mag;
	qstep_t           entry;
	qstep_t           stg_s [QUO_W+1];
	qstep_t           nxt [QUO_W];
	logic             vld_s [QUO_W+1];
	sample_t          res_q;
	logic             vld_q;

	always_comb begin
		mag       = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
		entry.neg = num[ACC_W-1];
		entry.rem = (DV_W'(mag) << 1) + DV_W'(wsum);
		entry.dvs = DV_W'(wsum) << 1;
		entry.quo = '0;
	end

	// Stage t decides quotient bit QUO_W-1-t.
	for (genvar t = 0; t < QUO_W; t++) begin : g_step
		logic [DV_W-1:0] sh;
		always_comb begin
			sh     = stg_s[t].dvs << (QUO_W - 1 - t);
			nxt[t] = stg_s[t];
			if (stg_s[t].rem >= sh) begin
				nxt[t].rem                  = stg_s[t].rem - sh;
				nxt[t].quo[QUO_W - 1 - t]   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QUO_W; i++) vld_s[i] <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 0; i < QUO_W; i++) vld_s[i+1] <= vld_s[i];
			vld_q <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= entry;
		for (int i = 0; i < QUO_W; i++) stg_s[i+1] <= nxt[i];
		res_q <= stg_s[QUO_W].neg ? sample_t'(~stg_s[QUO_W].quo + 1'b1)
			: sample_t'(stg_s[QUO_W].quo);
	end

	assign out_valid = vld_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== sv/fuzzy_controller_two_input.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fuzzy_controller_two_input
// Two-input fuzzy controller with five triangular sets per input, min rule
// firing, a fixed rule table and a weighted-average singleton output.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high; busy is always low, so one
//   sample can be taken on every clock. Inputs and output are signed Q8.8.
//   Each sample yields exactly one result: drive_out is valid for the single
//   cycle in which done is high. The depth comes from the membership divider
//   (one bit per stage) and the output divider (one quotient bit per stage);
//   throughput is one sample per cycle. The receiver cannot stall the block,
//   and results are never held back.
//   The five centers are written through wr_en / wr_index / wr_data; the user
//   must write them only while no transaction is in flight, which the block
//   itself does not enforce. Indexes beyond the fifth are ignored.
//   Reset clears every valid bit in flight and loads the default centers
//   -75, -37.5, 0, 37.5 and 75.
// ---------------------------------------------------------------------------
module fuzzy_controller_two_input (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fcti_pkg::sample_t first_input,
	input  fcti_pkg::sample_t second_input,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output logic              done,
	output fcti_pkg::sample_t drive_out
);
	import fcti_pkg::*;

	typedef enum logic [2:0] {
		REG_CENTER_ONE   = 3'd0,
		REG_CENTER_TWO   = 3'd1,
		REG_CENTER_THREE = 3'd2,
		REG_CENTER_FOUR  = 3'd3,
		REG_CENTER_FIVE  = 3'd4
	} reg_idx_t;

	centers_t                centers_q;
	logic                    accept;
	logic                    fa_valid, fb_valid;
	fuzz_t                   fz_a, fz_b;
	logic                    rl_valid;
	logic signed [ACC_W-1:0] rl_num;
	logic [WSUM_W-1:0]       rl_wsum;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centers_q[0] <= -16'sd19200;
			centers_q[1] <= -16'sd9600;
			centers_q[2] <= 16'sd0;
			centers_q[3] <= 16'sd9600;
			centers_q[4] <= 16'sd19200;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_ONE:   centers_q[0] <= wr_data;
				REG_CENTER_TWO:   centers_q[1] <= wr_data;
				REG_CENTER_THREE: centers_q[2] <= wr_data;
				REG_CENTER_FOUR:  centers_q[3] <= wr_data;
				REG_CENTER_FIVE:  centers_q[4] <= wr_data;
				default: ;
			endcase
		end
	end

	fcti_fuzz u_fuzz_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.x         (first_input),
		.centers   (centers_q),
		.out_valid (fa_valid),
		.fz        (fz_a)
	);

	fcti_fuzz u_fuzz_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.x         (second_input),
		.centers   (centers_q),
		.out_valid (fb_valid),
		.fz        (fz_b)
	);

	fcti_rules u_rules (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fa_valid && fb_valid),
		.fz_a      (fz_a),
		.fz_b      (fz_b),
		.centers   (centers_q),
		.out_valid (rl_valid),
		.num       (rl_num),
		.wsum      (rl_wsum)
	);

	fcti_wdiv u_wdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rl_valid),
		.num       (rl_num),
		.wsum      (rl_wsum),
		.out_valid (done),
		.res       (drive_out)
	);

	// Both membership pipelines run in lockstep.
	a_fuzz_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		fa_valid == fb_valid)
		else $error("membership pipelines out of step");

	// Degrees of adjacent sets always sum to one, so the weight sum is never zero.
	a_wsum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rl_valid |-> rl_wsum != '0)
		else $error("zero weight sum reached the divider");

	// Every result traces back to an earlier accepted transaction.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching transaction");

endmodule
`default_nettype wire

// ===== bench/tb_fuzzy_controller_two_input.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_fuzzy_controller_two_input
// Drives samples into the fuzzy controller, predicts each output with an
// independent model of fuzzification, min-rule firing and rounded
// weighted-average defuzzification, and checks every result in order.
// ---------------------------------------------------------------------------
module tb_fuzzy_controller_two_input;
	import fcti_pkg::*;

	localparam int CLK_HALF  = 4;
	localparam int LIMIT_CYC = 400000;
	localparam logic [2:0] REG_C1 = 3'd0;
	localparam logic [2:0] REG_C2 = 3'd1;
	localparam logic [2:0] REG_C3 = 3'd2;
	localparam logic [2:0] REG_C4 = 3'd3;
	localparam logic [2:0] REG_C5 = 3'd4;
	localparam int NUM_DIRECTED = 14;

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic        has_gold;
		logic [15:0] gold;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	sample_t     first_input;
	sample_t     second_input;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;
	logic        done;
	sample_t     drive_out;

	logic signed [15:0] centers [5];
	logic [15:0]        drive_q [$];
	int                 errors;
	int                 cycles;
	stim_row_t          directed [NUM_DIRECTED];

	fuzzy_controller_two_input i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_input(first_input), .second_input(second_input),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .drive_out(drive_out)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Active sets and degrees of one clamped input.
	function automatic void fuzzify(input longint x, output int s0, output int s1,
			output longint d0, output longint d1, output int cnt);
		longint one;
		longint up;
		one = 64'sd1 <<< FRAC_BITS;
		s0 = 0; s1 = 0; d0 = 0; d1 = 0;
		if (x < centers[0]) begin
			s0 = 0; d0 = one; cnt = 1;
			return;
		end
		for (int k = 0; k < 4; k++) begin
			if (x < centers[k+1]) begin
				up = ((x - centers[k]) <<< FRAC_BITS) / (centers[k+1] - centers[k]);
				s0 = k; d0 = one - up; s1 = k + 1; d1 = up; cnt = 2;
				return;
			end
		end
		s0 = 4; d0 = one; cnt = 1;
	endfunction

	function automatic logic [15:0] controller_drive(input logic [15:0] a, input logic [15:0] b);
		longint lim;
		longint xa;
		longint xb;
		int sa [2];
		int sb [2];
		longint da [2];
		longint db [2];
		int na;
		int nb;
		longint w;
		longint num;
		longint den;
		longint mag;
		longint q;
		lim = 100 * (64'sd1 <<< FRAC_BITS);
		xa = longint'($signed(a));
		xb = longint'($signed(b));
		if (xa < -lim) xa = -lim;
		if (xa > lim) xa = lim;
		if (xb < -lim) xb = -lim;
		if (xb > lim) xb = lim;
		fuzzify(xa, sa[0], sa[1], da[0], da[1], na);
		fuzzify(xb, sb[0], sb[1], db[0], db[1], nb);
		num = 0; den = 0;
		for (int i = 0; i < na; i++) begin
			for (int j = 0; j < nb; j++) begin
				w = (da[i] < db[j]) ? da[i] : db[j];
				num += w * centers[RULE_TBL[sa[i]*NSETS + sb[j]]];
				den += w;
			end
		end
		if (den == 0) return 16'h0000;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? 16'(-q) : 16'(q);
	endfunction

	// Leaves wr_en high; the caller drops it after the last write.
	task automatic write_center(input logic [2:0] idx, input logic [15:0] val);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
		@(posedge clk);
		if (idx < 5) centers[idx] = val;
	endtask

	task automatic load_centers(input int c1, input int c2, input int c3, input int c4, input int c5);
		write_center(REG_C1, 16'(c1));
		write_center(REG_C2, 16'(c2));
		write_center(REG_C3, 16'(c3));
		write_center(REG_C4, 16'(c4));
		write_center(REG_C5, 16'(c5));
	endtask

	// Drains all results, then lets the pipeline settle before a write.
	task automatic wait_idle();
		while (drive_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] a, input logic [15:0] b, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1; first_input <= a; second_input <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		drive_q = {drive_q, controller_drive(a, b)};
	endtask

	function automatic logic [15:0] rand_input();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'h8000;
			2: return 16'h7FFF;
			default: return 16'($signed($urandom_range(0, 56000)) - 28000);
		endcase
	endfunction

	task automatic random_phase(input int count, input bit may_idle);
		for (int n = 0; n < count; n++) send_sample(rand_input(), rand_input(), may_idle);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected result drive_out=%0d", $time, drive_out);
				errors++;
			end else begin
				if (drive_out !== drive_q[0]) begin
					$display("%0t: drive_out mismatch expected=%0d actual=%0d", $time,
						$signed(drive_q[0]), drive_out);
					errors++;
				end
				void'(drive_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		errors = 0; cycles = 0;
		arst_n = 1'b0; start = 1'b0; first_input = '0; second_input = '0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		centers[0] = -19200; centers[1] = -9600; centers[2] = 0;
		centers[3] = 9600; centers[4] = 19200;
		// Golden values at the default centers follow from the rule table directly.
		directed[0]  = '{16'h8000, 16'h8000, 1'b1, 16'(-19200)};
		directed[1]  = '{16'h7FFF, 16'h7FFF, 1'b1, 16'(19200)};
		directed[2]  = '{16'h8000, 16'h7FFF, 1'b1, 16'(9600)};
		directed[3]  = '{16'h7FFF, 16'h8000, 1'b1, 16'(-9600)};
		directed[4]  = '{16'd0, 16'd0, 1'b1, 16'd0};
		directed[5]  = '{16'(-25600), 16'(25600), 1'b1, 16'(9600)};
		directed[6]  = '{16'(-25601), 16'(25601), 1'b0, 16'd0};
		directed[7]  = '{16'(9600), 16'(-9600), 1'b0, 16'd0};
		directed[8]  = '{16'(-9600), 16'(9600), 1'b0, 16'd0};
		directed[9]  = '{16'(4800), 16'(-4801), 1'b0, 16'd0};
		directed[10] = '{16'(19199), 16'(-19199), 1'b0, 16'd0};
		directed[11] = '{16'(-14400), 16'(14401), 1'b0, 16'd0};
		directed[12] = '{16'hFFFF, 16'h0001, 1'b0, 16'd0};
		directed[13] = '{16'h5555, 16'hAAAA, 1'b0, 16'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_DIRECTED; r++) begin
			send_sample(directed[r].a, directed[r].b, 1'b0);
			if (directed[r].has_gold) drive_q[drive_q.size()-1] = directed[r].gold;
		end
		start <= 1'b0;
		wait_idle();

		// Extreme spread of centers.
		load_centers(-25600, -12800, 0, 12800, 25600);
		wr_en <= 1'b0;
		random_phase(300, 1'b1);
		wait_idle();
		// Narrow cluster near zero, asymmetric.
		load_centers(-3, -1, 0, 2, 300);
		wr_en <= 1'b0;
		random_phase(300, 1'b1);
		wait_idle();
		// Centers out of order, mostly at the two extremes.
		load_centers(25600, -25600, 25600, 100, -25600);
		wr_en <= 1'b0;
		random_phase(300, 1'b1);
		wait_idle();
		// Equal centers and an ignored index.
		load_centers(-25600, -25600, 5, 5, 25600);
		write_center(3'd7, 16'h1234);
		wr_en <= 1'b0;
		random_phase(300, 1'b1);
		wait_idle();
		load_centers($signed($urandom_range(0, 51200)) - 25600, -6000, 1000, 7000, 22000);
		wr_en <= 1'b0;
		random_phase(300, 1'b1);
		wait_idle();
		load_centers(-19200, -9600, 0, 9600, 19200);
		wr_en <= 1'b0;
		// Idle gaps first, then back-to-back transactions to the end.
		for (int n = 0; n < 500; n++) send_sample(rand_input(), rand_input(), n < 200);
		start <= 1'b0;

		while (drive_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fcti_pkg.sv
sv/fcti_fuzz.sv
sv/fcti_rules.sv
sv/fcti_wdiv.sv
sv/fuzzy_controller_two_input.sv
bench/tb_fuzzy_controller_two_input.sv
